/* hdl/ntc_pkg.sv */
`timescale 1ns / 1ps
// ntc linearizer package: widths, register indexes, segment tables, sequencer states
package ntc_pkg;

  // converter and averaging
  localparam int ADC_BITS    = 10;
  localparam int SAMPLES     = 10;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = 6;

  // configuration registers
  localparam int REF_W       = 13;
  localparam int SER_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_REF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SERIES = 2'd1;
  localparam logic [REF_W-1:0] REF_RESET    = 13'd3300;
  localparam logic [SER_W-1:0] SERIES_RESET = 17'd10000;

  // result
  localparam int TEMP_W      = 10;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 10'd700;

  // group queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // arithmetic
  localparam int MV_PROD_W   = SUM_W + REF_W;
  localparam int MV_FULL_W   = MV_PROD_W - ADC_BITS;
  localparam int DIV_W       = REF_W + SER_W;
  localparam int DEN_W       = 18;
  localparam int DIV_CNT_W   = 5;
  localparam int DIST_W      = 16;
  localparam int SCALE_W     = 10;
  localparam logic [SCALE_W-1:0] TENTHS_SCALE = 10'd1000;

  // average by reciprocal multiply, exact for any group size up to 64
  localparam int AVG_SHIFT   = SUM_W + 6;
  localparam int AVG_RECIP_W = AVG_SHIFT + 1;
  localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
  localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
    AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

  // piecewise linear segments, first match wins
  localparam int SEG_COUNT   = 7;
  localparam int SEG_IDX_W   = 3;
  localparam logic [DIST_W-1:0] SEG_TOP [SEG_COUNT] =
    '{16'd33970, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
  localparam logic [DIST_W-1:0] SEG_LOW [SEG_COUNT] =
    '{16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484, 16'd1756};
  localparam logic [DEN_W-1:0] SEG_SLOPE [SEG_COUNT] =
    '{18'd136600, 18'd77400, 18'd45370, 18'd27370, 18'd17130, 18'd11030, 18'd7280};
  localparam logic [TEMP_W-1:0] SEG_BASE [SEG_COUNT] =
    '{10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500, 10'd600};

  // scale over slope as rounded-up reciprocals; offset times error stays below 2^32
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = 30;
  localparam int T_PROD_W    = DIST_W + RECIP_W;
  localparam longint unsigned RECIP_NUM = 64'(TENTHS_SCALE) << RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_COUNT] = '{
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[0]) - 64'd1) / 64'(SEG_SLOPE[0])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[1]) - 64'd1) / 64'(SEG_SLOPE[1])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[2]) - 64'd1) / 64'(SEG_SLOPE[2])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[3]) - 64'd1) / 64'(SEG_SLOPE[3])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[4]) - 64'd1) / 64'(SEG_SLOPE[4])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[5]) - 64'd1) / 64'(SEG_SLOPE[5])),
    RECIP_W'((RECIP_NUM + 64'(SEG_SLOPE[6]) - 64'd1) / 64'(SEG_SLOPE[6]))
  };

  typedef struct packed {
    logic [REF_W-1:0] ref_mv;
    logic [SER_W-1:0] series_ohms;
  } cfg_t;

  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } q_push_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } q_head_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_AVG,
    BK_MV_MUL,
    BK_MV_CHK,
    BK_R_MUL,
    BK_R_GO,
    BK_R_WAIT,
    BK_SEG,
    BK_T_MUL,
    BK_T_ADD,
    BK_EMIT
  } back_state_t;

endpackage

/* hdl/ntc_intf.sv */
`timescale 1ns / 1ps
// ntc linearizer channel interfaces: samples, results and configuration writes
interface ntc_sample_if;
  logic                         valid;
  logic                         ready;
  logic [ntc_pkg::ADC_BITS-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface ntc_result_if;
  logic                       valid;
  logic                       ready;
  logic [ntc_pkg::TEMP_W-1:0] temperature_tenths;
  logic                       out_of_range;
  modport source (output valid, output temperature_tenths, output out_of_range, input ready);
  modport sink   (input valid, input temperature_tenths, input out_of_range, output ready);
endinterface

interface ntc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ntc_pkg::CFG_IDX_W-1:0]  index;
  logic [ntc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/ntc_front.sv */
`timescale 1ns / 1ps
// ntc linearizer front: sample accumulation and group completion
module ntc_front (
  input  logic              clk,
  input  logic              rst,
  ntc_sample_if.sink        sample,
  input  logic              q_full,
  output ntc_pkg::q_push_t  push
);

  logic [ntc_pkg::SUM_W-1:0] sum;
  logic [ntc_pkg::CNT_W-1:0] count;
  logic [ntc_pkg::SUM_W-1:0] sum_next;
  logic                      last;
  logic                      accept;

  assign last         = (count == ntc_pkg::CNT_W'(ntc_pkg::SAMPLES - 1));
  // only the item that closes a group needs room in the queue
  assign sample.ready = !last || !q_full;
  assign accept       = sample.valid && sample.ready;
  assign sum_next     = sum + ntc_pkg::SUM_W'(sample.adc_sample);

  assign push.push = accept && last;
  assign push.sum  = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (accept) begin
      if (last) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count + 1'b1;
      end
    end
  end

endmodule

/* hdl/ntc_queue.sv */
`timescale 1ns / 1ps
// ntc linearizer group queue between front and back
module ntc_queue (
  input  logic              clk,
  input  logic              rst,
  input  ntc_pkg::q_push_t  push,
  input  logic              pop,
  output logic              full,
  output ntc_pkg::q_head_t  head
);

  logic [ntc_pkg::SUM_W-1:0]  slots [ntc_pkg::QUEUE_DEPTH];
  logic [ntc_pkg::QPTR_W-1:0] wr_ptr;
  logic [ntc_pkg::QPTR_W-1:0] rd_ptr;
  logic [ntc_pkg::QCNT_W-1:0] count;
  logic                       do_pop;

  assign full       = (count == ntc_pkg::QCNT_W'(ntc_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.sum   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.push && !full) begin
      slots[wr_ptr] <= push.sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/ntc_div.sv */
`timescale 1ns / 1ps
// ntc linearizer restoring divider, one quotient bit per cycle
module ntc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ntc_pkg::DIV_W-1:0]   dividend,
  input  logic [ntc_pkg::DEN_W-1:0]   divisor,
  output logic                        busy,
  output logic                        done,
  output logic [ntc_pkg::DIV_W-1:0]   quotient
);

  logic [ntc_pkg::DEN_W-1:0]     rem;
  logic [ntc_pkg::DEN_W-1:0]     den;
  logic [ntc_pkg::DIV_CNT_W-1:0] cnt;
  logic [ntc_pkg::DEN_W:0]       rem_sh;
  logic                          ge;
  logic [ntc_pkg::DEN_W:0]       rem_sub;

  assign rem_sh  = {rem, quotient[ntc_pkg::DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      den      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? rem_sub[ntc_pkg::DEN_W-1:0] : rem_sh[ntc_pkg::DEN_W-1:0];
      quotient <= {quotient[ntc_pkg::DIV_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ntc_pkg::DIV_CNT_W'(ntc_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/ntc_back.sv */
`timescale 1ns / 1ps
// ntc linearizer back: average, voltage, resistance and segment sequencer
module ntc_back (
  input  logic              clk,
  input  logic              rst,
  input  ntc_pkg::cfg_t     cfg,
  input  ntc_pkg::q_head_t  head,
  output logic              pop,
  ntc_result_if.source      result
);

  ntc_pkg::back_state_t state;
  ntc_pkg::back_state_t state_next;

  logic [ntc_pkg::DIV_W-1:0]      num;
  logic [ntc_pkg::DEN_W-1:0]      den;
  logic [ntc_pkg::AVG_PROD_W-1:0] avg_prod;
  logic [ntc_pkg::SUM_W-1:0]      avg;
  logic [ntc_pkg::MV_PROD_W-1:0]  prod_mv;
  logic [ntc_pkg::REF_W-1:0]      mv;
  logic [ntc_pkg::DIV_W-1:0]      res_ohms;
  logic [ntc_pkg::DIST_W-1:0]     top_gap;
  logic [ntc_pkg::SEG_IDX_W-1:0]  seg_idx;
  logic [ntc_pkg::T_PROD_W-1:0]   t_prod;
  logic [ntc_pkg::TEMP_W-1:0]     temp;
  logic                           oor;

  logic                          res_valid;
  logic [ntc_pkg::TEMP_W-1:0]    res_temp;
  logic                          res_oor;

  logic                          div_start;
  logic                          div_busy;
  logic                          div_done;
  logic [ntc_pkg::DIV_W-1:0]     div_quo;
  logic                          emit_load;
  logic                          mv_ok;
  logic                          seg_hit;
  logic [ntc_pkg::SEG_IDX_W-1:0] seg_sel;

  ntc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign mv_ok = (prod_mv[ntc_pkg::MV_PROD_W-1:ntc_pkg::ADC_BITS]
                  < ntc_pkg::MV_FULL_W'(cfg.ref_mv));

  // first matching segment; the top segment excludes its upper bound
  always_comb begin
    seg_hit = 1'b0;
    seg_sel = '0;
    for (int i = ntc_pkg::SEG_COUNT - 1; i >= 0; i--) begin
      if (((i == 0) ? (res_ohms < ntc_pkg::DIV_W'(ntc_pkg::SEG_TOP[i]))
                    : (res_ohms <= ntc_pkg::DIV_W'(ntc_pkg::SEG_TOP[i])))
          && (res_ohms > ntc_pkg::DIV_W'(ntc_pkg::SEG_LOW[i]))) begin
        seg_hit = 1'b1;
        seg_sel = ntc_pkg::SEG_IDX_W'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ntc_pkg::BK_IDLE:     if (head.valid) state_next = ntc_pkg::BK_AVG;
      ntc_pkg::BK_AVG:      state_next = ntc_pkg::BK_MV_MUL;
      ntc_pkg::BK_MV_MUL:   state_next = ntc_pkg::BK_MV_CHK;
      ntc_pkg::BK_MV_CHK:   state_next = mv_ok ? ntc_pkg::BK_R_MUL : ntc_pkg::BK_EMIT;
      ntc_pkg::BK_R_MUL:    state_next = ntc_pkg::BK_R_GO;
      ntc_pkg::BK_R_GO:     state_next = ntc_pkg::BK_R_WAIT;
      ntc_pkg::BK_R_WAIT:   if (div_done) state_next = ntc_pkg::BK_SEG;
      ntc_pkg::BK_SEG:      state_next = seg_hit ? ntc_pkg::BK_T_MUL : ntc_pkg::BK_EMIT;
      ntc_pkg::BK_T_MUL:    state_next = ntc_pkg::BK_T_ADD;
      ntc_pkg::BK_T_ADD:    state_next = ntc_pkg::BK_EMIT;
      ntc_pkg::BK_EMIT:     if (emit_load) state_next = ntc_pkg::BK_IDLE;
      default:              state_next = ntc_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    emit_load = 1'b0;
    case (state)
      ntc_pkg::BK_IDLE:   pop       = head.valid;
      ntc_pkg::BK_R_GO:   div_start = 1'b1;
      ntc_pkg::BK_EMIT:   emit_load = !res_valid || result.ready;
      default: begin
        pop       = 1'b0;
        div_start = 1'b0;
        emit_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntc_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ntc_pkg::BK_IDLE: begin
        avg_prod <= ntc_pkg::AVG_PROD_W'(head.sum) * ntc_pkg::AVG_PROD_W'(ntc_pkg::AVG_RECIP);
      end
      ntc_pkg::BK_AVG: begin
        avg <= avg_prod[ntc_pkg::AVG_SHIFT +: ntc_pkg::SUM_W];
      end
      ntc_pkg::BK_MV_MUL: begin
        prod_mv <= ntc_pkg::MV_PROD_W'(avg) * ntc_pkg::MV_PROD_W'(cfg.ref_mv);
      end
      ntc_pkg::BK_MV_CHK: begin
        mv   <= prod_mv[ntc_pkg::ADC_BITS +: ntc_pkg::REF_W];
        temp <= '0;
        oor  <= 1'b1;
      end
      ntc_pkg::BK_R_MUL: begin
        num <= ntc_pkg::DIV_W'(mv) * ntc_pkg::DIV_W'(cfg.series_ohms);
        den <= ntc_pkg::DEN_W'(cfg.ref_mv - mv);
      end
      ntc_pkg::BK_R_WAIT: begin
        res_ohms <= div_quo;
      end
      ntc_pkg::BK_SEG: begin
        seg_idx <= seg_sel;
        top_gap <= ntc_pkg::SEG_TOP[seg_sel] - res_ohms[ntc_pkg::DIST_W-1:0];
        temp    <= '0;
        oor     <= 1'b1;
      end
      ntc_pkg::BK_T_MUL: begin
        t_prod <= ntc_pkg::T_PROD_W'(top_gap) * ntc_pkg::T_PROD_W'(ntc_pkg::SEG_RECIP[seg_idx]);
      end
      ntc_pkg::BK_T_ADD: begin
        temp <= t_prod[ntc_pkg::RECIP_SHIFT +: ntc_pkg::TEMP_W] + ntc_pkg::SEG_BASE[seg_idx];
        oor  <= 1'b0;
      end
      default: begin
        num <= num;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      res_temp <= temp;
      res_oor  <= oor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result.valid              = res_valid;
  assign result.temperature_tenths = res_temp;
  assign result.out_of_range       = res_oor;

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_oor |-> res_temp == '0)
    else $error("out of range result with non-zero temperature");

  a_temp_span: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_oor |-> res_temp <= ntc_pkg::TEMP_MAX)
    else $error("temperature above table span");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_last_div: assert property (@(posedge clk) disable iff (rst)
    state == ntc_pkg::BK_R_WAIT && div_done |=> state == ntc_pkg::BK_SEG)
    else $error("sequencer missed resistance quotient");

endmodule

/* hdl/ntc_thermistor_linearizer_unit.sv */
`timescale 1ns / 1ps
// ntc thermistor linearizer top level: configuration registers and part wiring
//
//   channel   dir   handshake      payload
//   sample    in    valid/ready    adc_sample[9:0]
//   result    out   valid/ready    temperature_tenths[9:0], out_of_range
//   cfg       in    valid/ready    index[1:0], data[16:0]
//
// samples are taken one per cycle; every tenth closes a group and needs a free queue slot
// each group passes through the back sequencer and waits there on the one-bit-per-cycle
//   resistance divider, but skips the division when the voltage reaches the reference
//   and skips the temperature step when no segment matches
// the two-group queue lets the front keep taking samples while the back works or stalls
// rst is synchronous; it clears the accumulator, the queue, the sequencer and the
//   result valid flag, and loads the default reference and series resistor
// cfg is always ready; writes to unlisted indexes are dropped
module ntc_thermistor_linearizer_unit (
  input  logic          clk,
  input  logic          rst,
  ntc_sample_if.sink    sample,
  ntc_cfg_if.sink       cfg,
  ntc_result_if.source  result
);

  ntc_pkg::cfg_t     cfg_regs;
  ntc_pkg::q_push_t  q_push;
  ntc_pkg::q_head_t  q_head;
  logic              q_full;
  logic              q_pop;

  // configuration register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.ref_mv      <= ntc_pkg::REF_RESET;
      cfg_regs.series_ohms <= ntc_pkg::SERIES_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ntc_pkg::CFG_IDX_REF:    cfg_regs.ref_mv      <= cfg.data[ntc_pkg::REF_W-1:0];
        ntc_pkg::CFG_IDX_SERIES: cfg_regs.series_ohms <= cfg.data[ntc_pkg::SER_W-1:0];
        default:                 cfg_regs <= cfg_regs;
      endcase
    end
  end

  // front: accumulate samples, hand out group sums
  ntc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .q_full (q_full),
    .push   (q_push)
  );

  // queue of finished group sums
  ntc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .pop  (q_pop),
    .full (q_full),
    .head (q_head)
  );

  // back: average, millivolts, resistance, segment lookup, result register
  ntc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .head   (q_head),
    .pop    (q_pop),
    .result (result)
  );

endmodule
